### design/ibmh_pkg.sv
package ibmh_pkg;

  localparam int REQ_W = 3;
  localparam int ID_W  = 10;
  localparam int KEY_W = 32;
  localparam int ST_W  = 2;
  localparam int CNT_W = 11;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PEEK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_EMPTY  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd3;

  // heap read address source
  localparam logic [2:0] RD_POS    = 3'd0;
  localparam logic [2:0] RD_PARENT = 3'd1;
  localparam logic [2:0] RD_LEFT   = 3'd2;
  localparam logic [2:0] RD_RIGHT  = 3'd3;
  localparam logic [2:0] RD_TOP    = 3'd4;
  localparam logic [2:0] RD_LAST   = 3'd5;

  // write source
  localparam logic [1:0] WR_UP    = 2'd0;
  localparam logic [1:0] WR_DN    = 2'd1;
  localparam logic [1:0] WR_PLACE = 2'd2;

  // hole load source
  localparam logic [1:0] HOLE_POS = 2'd0;
  localparam logic [1:0] HOLE_NEW = 2'd1;
  localparam logic [1:0] HOLE_TOP = 2'd2;

  typedef struct packed {
    logic             load_req;
    logic             map_re;
    logic             heap_re;
    logic [2:0]       rd_sel;
    logic             latch_pos;
    logic             set_st;
    logic [ST_W-1:0]  st_code;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             cnt_clr;
    logic             hole_ld;
    logic [1:0]       hole_sel;
    logic             load_top;
    logic             load_last;
    logic             load_left;
    logic             wr_en;
    logic [1:0]       wr_sel;
    logic             out_load;
  } ibmh_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             id_ok;
    logic             cnt_zero;
    logic             full;
    logic             present;
    logic             del_resift;
    logic             pop_more;
    logic             hole_top;
    logic             up_less;
    logic             dn_has_left;
    logic             dn_has_right;
    logic             dn_less;
  } ibmh_stat_t;

endpackage

### design/ibmh_ram.sv
module ibmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/ibmh_datapath.sv
module ibmh_datapath #(
  parameter int CAPACITY = 1024,
  parameter int NUM_IDS  = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [ibmh_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [ibmh_pkg::REQ_W-1:0]         in_tuser,
  input  ibmh_pkg::ibmh_cmd_t                cmd,
  output ibmh_pkg::ibmh_stat_t               stat,
  output logic [ibmh_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [ibmh_pkg::ST_W-1:0]          out_tuser
);
  import ibmh_pkg::*;

  localparam int SW  = $clog2(CAPACITY + 1);
  localparam int HAW = $clog2(CAPACITY);
  localparam int MAW = $clog2(NUM_IDS);
  localparam int HW  = ID_W + KEY_W;

  logic [REQ_W-1:0] req_r;
  logic [ID_W-1:0]  id_r;
  logic [KEY_W-1:0] key_r;
  logic [SW-1:0]    pos_r, cnt_r, hole_r;
  logic [ID_W-1:0]  ch_id_r;
  logic [KEY_W-1:0] ch_key_r;
  logic [SW-1:0]    ch_slot_r;
  logic             right_ok_r;
  logic [ST_W-1:0]  st_r;
  logic [ID_W-1:0]  res_id_r;
  logic [KEY_W-1:0] res_key_r;
  logic [ST_W-1:0]  o_st_r;
  logic [ID_W-1:0]  o_id_r;
  logic [KEY_W-1:0] o_key_r;
  logic [CNT_W-1:0] o_cnt_r;

  logic [HW-1:0]    heap_rdata, heap_wdata;
  logic [ID_W-1:0]  rd_id;
  logic [KEY_W-1:0] rd_key;
  logic [SW-1:0]    map_rdata;
  logic [SW-1:0]    rd_slot;
  logic [HAW-1:0]   heap_raddr, heap_waddr;
  logic [ID_W-1:0]  mw_id;
  logic [SW:0]      dbl, dbl_p1, cnt_ext;
  logic             use_right;
  logic [ID_W-1:0]  best_id;
  logic [KEY_W-1:0] best_key;
  logic [SW-1:0]    best_slot;

  assign rd_id   = heap_rdata[ID_W-1:0];
  assign rd_key  = heap_rdata[HW-1:ID_W];
  assign dbl     = {hole_r, 1'b0};
  assign dbl_p1  = {hole_r, 1'b1};
  assign cnt_ext = {1'b0, cnt_r};

  assign use_right = right_ok_r && (rd_key < ch_key_r);
  assign best_id   = use_right ? rd_id : ch_id_r;
  assign best_key  = use_right ? rd_key : ch_key_r;
  assign best_slot = use_right ? dbl_p1[SW-1:0] : ch_slot_r;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_POS:    rd_slot = map_rdata;
      RD_PARENT: rd_slot = hole_r >> 1;
      RD_LEFT:   rd_slot = dbl[SW-1:0];
      RD_RIGHT:  rd_slot = dbl_p1[SW-1:0];
      RD_TOP:    rd_slot = SW'(1);
      default:   rd_slot = cnt_r;
    endcase
  end
  // slot s lives at address s-1
  assign heap_raddr = HAW'(rd_slot - SW'(1));
  assign heap_waddr = HAW'(hole_r - SW'(1));

  always_comb begin
    unique case (cmd.wr_sel)
      WR_UP: begin
        heap_wdata = {rd_key, rd_id};
        mw_id      = rd_id;
      end
      WR_DN: begin
        heap_wdata = {best_key, best_id};
        mw_id      = best_id;
      end
      default: begin
        heap_wdata = {key_r, id_r};
        mw_id      = id_r;
      end
    endcase
  end

  ibmh_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .re    (cmd.heap_re),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  // position entries are never cleared; an entry only counts when the slot it
  // names is in use and holds that same id
  ibmh_ram #(.WIDTH(SW), .DEPTH(NUM_IDS)) u_pos_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (MAW'(mw_id)),
    .wdata (hole_r),
    .re    (cmd.map_re),
    .raddr (MAW'(id_r)),
    .rdata (map_rdata)
  );

  assign stat.req          = req_r;
  assign stat.id_ok        = 32'(id_r) < 32'(NUM_IDS);
  assign stat.cnt_zero     = cnt_r == '0;
  assign stat.full         = cnt_r >= SW'(CAPACITY);
  assign stat.present      = (pos_r != '0) && (pos_r <= cnt_r) && (rd_id == id_r);
  assign stat.del_resift   = pos_r < cnt_r;
  assign stat.pop_more     = cnt_r != SW'(1);
  assign stat.hole_top     = hole_r == SW'(1);
  assign stat.up_less      = key_r < rd_key;
  assign stat.dn_has_left  = dbl <= cnt_ext;
  assign stat.dn_has_right = dbl != cnt_ext;
  assign stat.dn_less      = best_key < key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + SW'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r     <= in_tuser;
      id_r      <= in_tdata[ID_W-1:0];
      key_r     <= in_tdata[ID_W+KEY_W-1:ID_W];
      st_r      <= ST_OK;
      res_id_r  <= '0;
      res_key_r <= '0;
    end
    if (cmd.set_st) begin
      st_r <= cmd.st_code;
    end
    if (cmd.latch_pos) begin
      pos_r <= map_rdata;
    end
    if (cmd.load_top) begin
      res_id_r  <= rd_id;
      res_key_r <= rd_key;
    end
    if (cmd.load_last) begin
      id_r  <= rd_id;
      key_r <= rd_key;
    end
    if (cmd.load_left) begin
      ch_id_r    <= rd_id;
      ch_key_r   <= rd_key;
      ch_slot_r  <= dbl[SW-1:0];
      right_ok_r <= stat.dn_has_right;
    end
    if (cmd.hole_ld) begin
      unique case (cmd.hole_sel)
        HOLE_POS: hole_r <= pos_r;
        HOLE_NEW: hole_r <= cnt_r + SW'(1);
        default:  hole_r <= SW'(1);
      endcase
    end else if (cmd.wr_en && cmd.wr_sel == WR_UP) begin
      hole_r <= hole_r >> 1;
    end else if (cmd.wr_en && cmd.wr_sel == WR_DN) begin
      hole_r <= best_slot;
    end
    if (cmd.out_load) begin
      o_st_r  <= st_r;
      o_id_r  <= res_id_r;
      o_key_r <= res_key_r;
      o_cnt_r <= CNT_W'(cnt_r);
    end
  end

  assign out_tuser = o_st_r;
  assign out_tdata = {{(OUT_DATA_W - CNT_W - KEY_W - ID_W){1'b0}}, o_cnt_r, o_key_r, o_id_r};

endmodule

### design/ibmh_ctrl.sv
module ibmh_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  ibmh_pkg::ibmh_stat_t  stat,
  output ibmh_pkg::ibmh_cmd_t   cmd
);
  import ibmh_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_LOOKUP = 4'd2;
  localparam logic [3:0] S_VERIFY = 4'd3;
  localparam logic [3:0] S_DLAST  = 4'd4;
  localparam logic [3:0] S_TOPW   = 4'd5;
  localparam logic [3:0] S_PLAST  = 4'd6;
  localparam logic [3:0] S_UP_RD  = 4'd7;
  localparam logic [3:0] S_UP_CMP = 4'd8;
  localparam logic [3:0] S_DN_RDL = 4'd9;
  localparam logic [3:0] S_DN_RDR = 4'd10;
  localparam logic [3:0] S_DN_SEL = 4'd11;
  localparam logic [3:0] S_PLACE  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       down_ok_r, down_ok_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    down_ok_nxt = down_ok_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        priority if (stat.req == REQ_INSERT || stat.req == REQ_DELETE) begin
          if (stat.id_ok) begin
            cmd.map_re = 1'b1;
            state_nxt  = S_LOOKUP;
          end else begin
            cmd.set_st  = 1'b1;
            cmd.st_code = (stat.req == REQ_INSERT) ? ST_FULL : ST_ABSENT;
            state_nxt   = S_DONE;
          end
        end else if (stat.req == REQ_POP || stat.req == REQ_PEEK) begin
          if (stat.cnt_zero) begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_EMPTY;
            state_nxt   = S_DONE;
          end else begin
            cmd.heap_re = 1'b1;
            cmd.rd_sel  = RD_TOP;
            state_nxt   = S_TOPW;
          end
        end else if (stat.req == REQ_EMPTY) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_LOOKUP: begin
        cmd.heap_re   = 1'b1;
        cmd.rd_sel    = RD_POS;
        cmd.latch_pos = 1'b1;
        state_nxt     = S_VERIFY;
      end
      S_VERIFY: begin
        if (stat.req == REQ_INSERT) begin
          priority if (stat.present) begin
            cmd.hole_ld  = 1'b1;
            cmd.hole_sel = HOLE_POS;
            down_ok_nxt  = 1'b1;
            state_nxt    = S_UP_RD;
          end else if (stat.full) begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_FULL;
            state_nxt   = S_DONE;
          end else begin
            cmd.cnt_inc  = 1'b1;
            cmd.hole_ld  = 1'b1;
            cmd.hole_sel = HOLE_NEW;
            down_ok_nxt  = 1'b0;
            state_nxt    = S_UP_RD;
          end
        end else if (stat.present) begin
          cmd.heap_re = 1'b1;
          cmd.rd_sel  = RD_LAST;
          state_nxt   = S_DLAST;
        end else begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_ABSENT;
          state_nxt   = S_DONE;
        end
      end
      S_DLAST: begin
        // last entry fills the hole unless the hole was the last slot
        cmd.load_last = 1'b1;
        cmd.cnt_dec   = 1'b1;
        cmd.hole_ld   = 1'b1;
        cmd.hole_sel  = HOLE_POS;
        down_ok_nxt   = 1'b1;
        state_nxt     = stat.del_resift ? S_UP_RD : S_DONE;
      end
      S_TOPW: begin
        cmd.load_top = 1'b1;
        if (stat.req == REQ_POP) begin
          cmd.heap_re = 1'b1;
          cmd.rd_sel  = RD_LAST;
          state_nxt   = S_PLAST;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PLAST: begin
        cmd.load_last = 1'b1;
        cmd.cnt_dec   = 1'b1;
        cmd.hole_ld   = 1'b1;
        cmd.hole_sel  = HOLE_TOP;
        state_nxt     = stat.pop_more ? S_DN_RDL : S_DONE;
      end
      S_UP_RD: begin
        if (stat.hole_top) begin
          state_nxt = down_ok_r ? S_DN_RDL : S_PLACE;
        end else begin
          cmd.heap_re = 1'b1;
          cmd.rd_sel  = RD_PARENT;
          state_nxt   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_less) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_sel  = WR_UP;
          down_ok_nxt = 1'b0;
          state_nxt   = S_UP_RD;
        end else begin
          state_nxt = down_ok_r ? S_DN_RDL : S_PLACE;
        end
      end
      S_DN_RDL: begin
        if (stat.dn_has_left) begin
          cmd.heap_re = 1'b1;
          cmd.rd_sel  = RD_LEFT;
          state_nxt   = S_DN_RDR;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_DN_RDR: begin
        cmd.load_left = 1'b1;
        cmd.heap_re   = stat.dn_has_right;
        cmd.rd_sel    = RD_RIGHT;
        state_nxt     = S_DN_SEL;
      end
      S_DN_SEL: begin
        if (stat.dn_less) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_DN;
          state_nxt  = S_DN_RDL;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_PLACE;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      down_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      down_ok_r   <= down_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/indexed_binary_min_heap.sv
// One request in flight at a time. Each level climbed takes a parent read and
// a compare; each level descended takes a left read, a right read and a select,
// as the slot RAM has a single read port. Peek, empty and rejected requests do
// no sift. The result register frees the input side as soon as the result is
// loaded.
// Reset clears the count only; no clearing pass, position entries are checked
// against the slot they name.
module indexed_binary_min_heap #(
  parameter int CAPACITY = 1024,
  parameter int NUM_IDS  = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ibmh_pkg::IN_DATA_W-1:0]     in_tdata,  // elem_id, elem_key
  input  logic [ibmh_pkg::REQ_W-1:0]         in_tuser,  // req_type
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ibmh_pkg::OUT_DATA_W-1:0]    out_tdata, // out_id, out_key, count
  output logic [ibmh_pkg::ST_W-1:0]          out_tuser  // status
);
  import ibmh_pkg::*;

  ibmh_cmd_t  cmd;
  ibmh_stat_t stat;

  ibmh_datapath #(.CAPACITY(CAPACITY), .NUM_IDS(NUM_IDS)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  ibmh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

endmodule

### tb/indexed_binary_min_heap_tb.sv
module indexed_binary_min_heap_tb;
  import ibmh_pkg::*;

  localparam int SLOTS     = 1024;
  localparam int IDS       = 1024;
  localparam int MAX_CYCLE = 1000000;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } heap_req_t;

  typedef struct {
    logic [ST_W-1:0]  st;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
  } heap_resp_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [REQ_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [ST_W-1:0] out_tuser;

  indexed_binary_min_heap dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow heap
  logic [ID_W-1:0]  hp_id [1:SLOTS];
  logic [KEY_W-1:0] hp_key[1:SLOTS];
  int               id_slot[0:IDS-1];
  int               hp_count;

  heap_req_t  pend_q[$];
  heap_resp_t resp_q[$];
  heap_req_t  cur;
  int  errors, n_acc, n_resp, cycles, n_full_seen;
  int  in_idle, out_idle, hold_cnt;
  logic in_acc, no_idle, hold_done;

  function automatic void put_slot(int s, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
    hp_id[s]    = id;
    hp_key[s]   = key;
    id_slot[id] = s;
  endfunction

  function automatic void climb(int hole, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
    while (hole > 1 && key < hp_key[hole/2]) begin
      put_slot(hole, hp_id[hole/2], hp_key[hole/2]);
      hole = hole / 2;
    end
    put_slot(hole, id, key);
  endfunction

  function automatic void descend(int hole, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
    int c;
    while (2 * hole <= hp_count) begin
      c = 2 * hole;
      if (c != hp_count && hp_key[c+1] < hp_key[c]) c++;
      if (hp_key[c] < key) begin
        put_slot(hole, hp_id[c], hp_key[c]);
        hole = c;
      end else begin
        break;
      end
    end
    put_slot(hole, id, key);
  endfunction

  function automatic void reposition(int hole, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
    if (hole > 1 && hp_key[hole/2] > key) climb(hole, id, key);
    else descend(hole, id, key);
  endfunction

  function automatic heap_resp_t apply_request(heap_req_t r);
    heap_resp_t res;
    int pos;
    logic [ID_W-1:0]  lid;
    logic [KEY_W-1:0] lkey;
    res.st = ST_OK; res.id = '0; res.key = '0;
    case (r.req)
      REQ_INSERT: begin
        pos = id_slot[r.id];
        if (pos != 0 && pos <= hp_count) begin
          reposition(pos, r.id, r.key);
        end else if (hp_count >= SLOTS) begin
          res.st = ST_FULL;
        end else begin
          hp_count++;
          climb(hp_count, r.id, r.key);
        end
      end
      REQ_DELETE: begin
        pos = id_slot[r.id];
        if (pos == 0 || pos > hp_count) begin
          res.st = ST_ABSENT;
        end else begin
          lid = hp_id[hp_count];
          lkey = hp_key[hp_count];
          hp_count--;
          id_slot[r.id] = 0;
          if (pos <= hp_count) reposition(pos, lid, lkey);
        end
      end
      REQ_POP, REQ_PEEK: begin
        if (hp_count == 0) begin
          res.st = ST_EMPTY;
        end else begin
          res.id = hp_id[1];
          res.key = hp_key[1];
          if (r.req == REQ_POP) begin
            lid = hp_id[hp_count];
            lkey = hp_key[hp_count];
            id_slot[res.id] = 0;
            hp_count--;
            if (hp_count != 0) descend(1, lid, lkey);
          end
        end
      end
      REQ_EMPTY: begin
        for (int s = 1; s <= hp_count; s++) id_slot[hp_id[s]] = 0;
        hp_count = 0;
      end
      default: ;
    endcase
    res.cnt = hp_count[CNT_W-1:0];
    return res;
  endfunction

  function automatic void add_req(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                  logic [KEY_W-1:0] key);
    heap_req_t r;
    r.req = req; r.id = id; r.key = key;
    pend_q.push_back(r);
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    if ($urandom_range(0, 3) == 0) return ID_W'($urandom);
    return ID_W'($urandom_range(0, 47));
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_acc) begin
      // hold current transaction
    end else if (in_idle > 0) begin
      in_tvalid <= 1'b0;
      in_idle <= in_idle - 1;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      in_idle <= $urandom_range(0, 17);
    end else if (pend_q.size() > 0) begin
      cur = pend_q.pop_front();
      in_tvalid <= 1'b1;
      in_tuser <= cur.req;
      in_tdata <= {6'b0, cur.key, cur.id};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      resp_q.push_back(apply_request(cur));
      n_acc <= n_acc + 1;
    end
  end

  // receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!hold_done && n_acc >= 200) begin
      hold_done <= 1'b1;
      hold_cnt <= 400;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (out_idle > 0) begin
      out_idle <= out_idle - 1;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      out_idle <= $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    heap_resp_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_resp <= n_resp + 1;
      if (resp_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual st=%0d data=%h", $time,
                 out_tuser, out_tdata);
        errors++;
      end else begin
        e = resp_q.pop_front();
        if (e.st == ST_FULL) n_full_seen++;
        if (out_tuser !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_tuser);
          errors++;
        end
        if (out_tdata[9:0] !== e.id) begin
          $display("%0t: out_id expected %0d actual %0d", $time, e.id, out_tdata[9:0]);
          errors++;
        end
        if (out_tdata[41:10] !== e.key) begin
          $display("%0t: out_key expected %h actual %h", $time, e.key, out_tdata[41:10]);
          errors++;
        end
        if (out_tdata[52:42] !== e.cnt) begin
          $display("%0t: count expected %0d actual %0d", $time, e.cnt, out_tdata[52:42]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLE) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int k, base;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    in_acc = 1'b0;
    no_idle = 1'b0;
    hold_done = 1'b0;
    hold_cnt = 0;
    in_idle = 0;
    out_idle = 0;
    errors = 0; n_acc = 0; n_resp = 0; cycles = 0; n_full_seen = 0;
    hp_count = 0;
    for (int i = 0; i < IDS; i++) id_slot[i] = 0;

    // directed: empty heap, extremes, update up/down, ties, unused codes, clear
    add_req(REQ_PEEK, 0, 0);
    add_req(REQ_POP, 10'h3FF, 32'hFFFF_FFFF);
    add_req(REQ_DELETE, 0, 0);
    add_req(REQ_INSERT, 0, 0);
    add_req(REQ_INSERT, 10'h3FF, 32'hFFFF_FFFF);
    add_req(REQ_INSERT, 5, 100);
    add_req(REQ_INSERT, 6, 100);
    add_req(REQ_INSERT, 5, 0);
    add_req(REQ_INSERT, 10'h3FF, 1);
    add_req(REQ_INSERT, 0, 200);
    add_req(REQ_PEEK, 0, 0);
    add_req(REQ_DELETE, 5, 0);
    add_req(REQ_DELETE, 5, 0);
    add_req(3'd5, 10'h2AA, 32'h5555_5555);
    add_req(3'd6, 10'h155, 32'hAAAA_AAAA);
    add_req(3'd7, 10'h3FF, 32'hFFFF_FFFF);
    add_req(REQ_POP, 0, 0);
    add_req(REQ_POP, 0, 0);
    add_req(REQ_INSERT, 7, 32'hFFFF_FFFF);
    add_req(REQ_POP, 0, 0);
    add_req(REQ_POP, 0, 0);
    add_req(REQ_POP, 0, 0);
    add_req(REQ_INSERT, 8, 3);
    add_req(REQ_EMPTY, 0, 0);
    add_req(REQ_PEEK, 0, 0);

    // random mix on a small id pool so updates and deletes hit present ids
    for (int i = 0; i < 650; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45)      add_req(REQ_INSERT, rand_id(), rand_key());
      else if (k < 62) add_req(REQ_DELETE, rand_id(), $urandom);
      else if (k < 80) add_req(REQ_POP, ID_W'($urandom), $urandom);
      else if (k < 94) add_req(REQ_PEEK, ID_W'($urandom), $urandom);
      else if (k < 97) add_req(REQ_EMPTY, ID_W'($urandom), $urandom);
      else             add_req(REQ_W'($urandom_range(5, 7)), ID_W'($urandom), $urandom);
    end

    // fill to capacity with every id, then work on the full heap
    base = $urandom_range(0, 1023);
    for (int i = 0; i < IDS; i++)
      add_req(REQ_INSERT, ID_W'((i * 619 + base) % IDS), rand_key());
    for (int i = 0; i < 20; i++) add_req(REQ_INSERT, ID_W'($urandom), rand_key());
    add_req(REQ_PEEK, 0, 0);
    for (int i = 0; i < 20; i++) add_req(REQ_DELETE, ID_W'($urandom), 0);
    for (int i = 0; i < 20; i++) add_req(REQ_POP, 0, 0);
    add_req(REQ_EMPTY, 0, 0);
    add_req(REQ_POP, 0, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (pend_q.size() < 120);
    no_idle = 1'b1;
    wait (pend_q.size() == 0 && !in_tvalid);
    wait (resp_q.size() == 0);
    repeat (60) @(posedge clk);

    $display("%0d requests, %0d responses; directed corners, random mix, one full heap",
             n_acc, n_resp);
    $display("output held off for 400 cycles once, %0d dropped inserts, %0d errors",
             n_full_seen, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
design/ibmh_pkg.sv
design/ibmh_ram.sv
design/ibmh_datapath.sv
design/ibmh_ctrl.sv
design/indexed_binary_min_heap.sv
tb/indexed_binary_min_heap_tb.sv
